>>> rtl/itaf_pkg.sv
// itaf_pkg: shared types, opcodes and character helpers for the integer-to-ascii formatter
// used by itaf_ctrl, itaf_datapath and integer_to_ascii_formatter_top; no dependencies
package itaf_pkg;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_LHEX = 3'd2;
    localparam logic [2:0] OP_UHEX = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    localparam int unsigned CountW   = 31;
    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit;
    } itaf_cmd_t;

    typedef struct packed {
        logic op_dec;
        logic op_hex;
        logic conv_done;
        logic lead_done;
        logic emit_last;
        logic slot_free;
    } itaf_sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else if (upper) begin
            c = CH_UA + {4'd0, d - 4'd10};
        end else begin
            c = CH_LA + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

>>> rtl/itaf_ctrl.sv
// itaf_ctrl: sequencer for load, binary-to-bcd conversion, leading zero skip and emission
// depends on itaf_pkg for the command and status structs
module itaf_ctrl
    import itaf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  itaf_sts_t sts,
    output itaf_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.op_dec) begin
                        state_next = ST_CONV;
                    end else if (sts.op_hex) begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_CONV: begin
                cmd.conv = 1'b1;
                if (sts.conv_done) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (sts.lead_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.skip = 1'b1;
                end
            end
            ST_EMIT: begin
                if (sts.slot_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && sts.emit_last |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after last beat");

endmodule

>>> rtl/itaf_datapath.sv
// itaf_datapath: digit register, double-dabble step, prefix, output beat register, char count
// depends on itaf_pkg for opcodes, command/status structs and digit_char
module itaf_datapath
    import itaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        s_opcode,
    input  logic [63:0]       s_value,
    input  logic              s_restart_count,
    input  logic              m_ready,
    input  itaf_cmd_t         cmd,
    output itaf_sts_t         sts,
    output logic              m_valid,
    output logic [7:0]        m_text_char,
    output logic              m_last_char,
    output logic [CountW-1:0] m_chars_total
);

    logic [63:0]       dig_reg, dig_next;
    logic [31:0]       bin_reg, bin_next;
    logic [4:0]        ndig_reg, ndig_next;
    logic [4:0]        iter_reg, iter_next;
    logic [15:0]       pre_reg, pre_next;
    logic [1:0]        pre_cnt_reg, pre_cnt_next;
    logic              upper_reg, upper_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_text_reg, m_text_next;
    logic              m_last_reg, m_last_next;
    logic [CountW-1:0] m_total_reg, m_total_next;

    logic [31:0]       low;
    logic [31:0]       mag;
    logic              neg;
    logic [39:0]       bcd_adj;
    logic [CountW-1:0] count_inc;

    assign low = s_value[31:0];
    assign neg = (s_opcode == OP_SDEC) && low[31];
    assign mag = neg ? (32'd0 - low) : low;

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            bcd_adj[i*4 +: 4] = (dig_reg[24 + i*4 +: 4] >= 4'd5) ?
                                dig_reg[24 + i*4 +: 4] + 4'd3 : dig_reg[24 + i*4 +: 4];
        end
    end

    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    assign sts.op_dec    = (s_opcode == OP_SDEC) || (s_opcode == OP_UDEC);
    assign sts.op_hex    = (s_opcode == OP_LHEX) || (s_opcode == OP_UHEX) ||
                           (s_opcode == OP_PTR);
    assign sts.conv_done = (iter_reg == 5'd31);
    assign sts.lead_done = (ndig_reg == 5'd1) || (dig_reg[63:60] != 4'd0);
    assign sts.emit_last = (pre_cnt_reg == 2'd0) && (ndig_reg == 5'd1);
    assign sts.slot_free = !m_valid_reg || m_ready;

    always_comb begin
        dig_next     = dig_reg;
        bin_next     = bin_reg;
        ndig_next    = ndig_reg;
        iter_next    = iter_reg;
        pre_next     = pre_reg;
        pre_cnt_next = pre_cnt_reg;
        upper_next   = upper_reg;
        count_next   = count_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_text_next  = m_text_reg;
        m_last_next  = m_last_reg;
        m_total_next = m_total_reg;

        if (cmd.load) begin
            if (s_restart_count) begin
                count_next = '0;
            end
            iter_next    = '0;
            bin_next     = mag;
            upper_next   = (s_opcode == OP_UHEX);
            pre_next     = '0;
            pre_cnt_next = 2'd0;
            if (sts.op_dec) begin
                dig_next  = '0;
                ndig_next = 5'd10;
                if (neg) begin
                    pre_next     = {CH_MINUS, 8'h00};
                    pre_cnt_next = 2'd1;
                end
            end else if (s_opcode == OP_PTR) begin
                dig_next     = s_value;
                ndig_next    = 5'd16;
                pre_next     = {CH_ZERO, CH_X};
                pre_cnt_next = 2'd2;
            end else begin
                dig_next  = {low, 32'd0};
                ndig_next = 5'd8;
            end
        end

        if (cmd.conv) begin
            dig_next  = {bcd_adj[38:0], bin_reg[31], 24'd0};
            bin_next  = {bin_reg[30:0], 1'b0};
            iter_next = iter_reg + 5'd1;
        end

        if (cmd.skip) begin
            dig_next  = {dig_reg[59:0], 4'd0};
            ndig_next = ndig_reg - 5'd1;
        end

        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_last_next  = sts.emit_last;
            m_total_next = count_inc;
            count_next   = count_inc;
            if (pre_cnt_reg != 2'd0) begin
                m_text_next  = pre_reg[15:8];
                pre_next     = {pre_reg[7:0], 8'h00};
                pre_cnt_next = pre_cnt_reg - 2'd1;
            end else begin
                m_text_next = digit_char(dig_reg[63:60], upper_reg);
                dig_next    = {dig_reg[59:0], 4'd0};
                ndig_next   = ndig_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            pre_cnt_reg <= 2'd0;
            ndig_reg    <= 5'd1;
            iter_reg    <= '0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            pre_cnt_reg <= pre_cnt_next;
            ndig_reg    <= ndig_next;
            iter_reg    <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg     <= dig_next;
        bin_reg     <= bin_next;
        pre_reg     <= pre_next;
        upper_reg   <= upper_next;
        m_text_reg  <= m_text_next;
        m_last_reg  <= m_last_next;
        m_total_reg <= m_total_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_text_char   = m_text_reg;
    assign m_last_char   = m_last_reg;
    assign m_chars_total = m_total_reg;

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.slot_free)
        else $error("beat loaded over an unaccepted beat");

    a_skip_keeps_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.skip |-> ndig_reg > 5'd1)
        else $error("leading zero skip removed the last digit");

    a_total_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_total_reg != '0)
        else $error("beat carries a zero character count");

endmodule

>>> rtl/integer_to_ascii_formatter_top.sv
// integer_to_ascii_formatter_top: printf-style %d %u %x %X %p integer text formatter
// instantiates itaf_ctrl and itaf_datapath, uses itaf_pkg
//
//  channel | direction | ports                                              | beat
//  s_      | in        | s_valid s_ready s_opcode s_value s_restart_count   | one number
//  m_      | out       | m_valid m_ready m_text_char m_last_char m_chars_total | one character
//
// a number is accepted, then decimal opcodes run the double-dabble conversion
// then suppressed leading zeros are skipped (up to 9 decimal, 7 hex, 15 pointer)
// then one character per cycle, up to 18, paced by m_ready through the output register
// unused opcodes are accepted and give no beats
// aresetn is synchronous active low and clears the character count
module integer_to_ascii_formatter_top
    import itaf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_opcode,
    input  logic [63:0]       s_value,
    input  logic              s_restart_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_text_char,
    output logic              m_last_char,
    output logic [CountW-1:0] m_chars_total
);

    itaf_cmd_t cmd;
    itaf_sts_t sts;

    itaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    itaf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_opcode),
        .s_value         (s_value),
        .s_restart_count (s_restart_count),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_text_char     (m_text_char),
        .m_last_char     (m_last_char),
        .m_chars_total   (m_chars_total)
    );

endmodule
